// ===== sv/i2c_master_byte_engine_assert.svh =====
// assertion macros shared by the i2c master byte engine
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/i2cm_pkg.sv =====
`default_nettype none

package i2cm_pkg;

  // configuration register indexes
  localparam logic [1:0] CfgHalfPeriod = 2'd0;
  localparam logic [1:0] CfgPollLimit  = 2'd1;

  // register reset values
  localparam logic [15:0] HalfPeriodRst = 16'd100;
  localparam logic [7:0]  PollLimitRst  = 8'd10;

  // bits per byte on the bus
  localparam logic [3:0] BitsPerByte = 4'd8;

  // command codes on the input side
  localparam logic [1:0] CmdStart = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;
  localparam logic [1:0] CmdStop  = 2'd3;

  // decoded command, at most one bit set
  typedef struct packed {
    logic is_start;
    logic is_write;
    logic is_read;
    logic is_stop;
  } cmd_kind_t;

  // one classified tick as it sits in the queue
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       stop_after;
    logic       sda_in;
  } item_t;

  // queue status towards the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // bus phases
  typedef enum logic [15:0] {
    PH_IDLE    = 16'h0001,
    PH_S_PREP  = 16'h0002,
    PH_S_HIGH  = 16'h0004,
    PH_S_FALL  = 16'h0008,
    PH_W_LOW   = 16'h0010,
    PH_W_HIGH  = 16'h0020,
    PH_WA_LOW  = 16'h0040,
    PH_WA_POLL = 16'h0080,
    PH_WA_HOLD = 16'h0100,
    PH_R_LOW   = 16'h0200,
    PH_R_HIGH  = 16'h0400,
    PH_RA_LOW  = 16'h0800,
    PH_RA_HIGH = 16'h1000,
    PH_P_LOW   = 16'h2000,
    PH_P_HIGH  = 16'h4000,
    PH_P_REL   = 16'h8000
  } phase_t;

endpackage

`default_nettype wire

// ===== sv/i2cm_front.sv =====
`default_nettype none

module i2cm_front
  import i2cm_pkg::*;
(
  input  wire logic       cmd_valid,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] tx_byte,
  input  wire logic       send_ack,
  input  wire logic       stop_after,
  input  wire logic       sda_in,
  output item_t           item
);

  // decode the command into one flag per kind
  always_comb begin
    item.kind = '0;
    if (cmd_valid) begin
      case (cmd)
        CmdStart: item.kind.is_start = 1'b1;
        CmdWrite: item.kind.is_write = 1'b1;
        CmdRead:  item.kind.is_read  = 1'b1;
        CmdStop:  item.kind.is_stop  = 1'b1;
        default:  item.kind = '0;
      endcase
    end
    item.tx_byte    = tx_byte;
    item.send_ack   = send_ack;
    // stop_after only matters for byte transfers
    item.stop_after = stop_after & (item.kind.is_write | item.kind.is_read);
    item.sda_in     = sda_in;
  end

endmodule

`default_nettype wire

// ===== sv/i2cm_queue.sv =====
`default_nettype none

module i2cm_queue
  import i2cm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      pop_item,
  output q_stat_t    stat
);

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r,  count_nxt;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // two payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item   = slot_r[rd_ptr_r];
  assign stat.full  = count_r[1];
  assign stat.empty = (count_r == 2'd0);

endmodule

`default_nettype wire

// ===== sv/i2cm_back.sv =====
`default_nettype none

module i2cm_back
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] half_period,
  input  wire logic [7:0]  poll_limit,
  input  wire logic        avail,
  input  wire item_t       item,
  output logic             take,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_data
);

  phase_t      ph_r,      ph_nxt;
  logic [3:0]  bit_r,     bit_nxt;
  logic [7:0]  shift_r,   shift_nxt;
  logic [15:0] tick_r,    tick_nxt;
  logic [7:0]  poll_r,    poll_nxt;
  logic        scl_r,     scl_nxt;
  logic        sda_r,     sda_nxt;
  logic        pend_r,    pend_nxt;
  logic        ack_r,     ack_nxt;
  logic [7:0]  rx_r,      rx_nxt;
  logic        status_r,  status_nxt;
  logic        ovalid_r,  ovalid_nxt;
  logic [15:0] odata_r;

  logic        ent;
  phase_t      ent_ph;
  logic        done;
  logic [15:0] half;
  logic [16:0] tick_inc;

  // a zero half period behaves as one tick
  assign half     = (half_period == 16'd0) ? 16'd1 : half_period;
  assign tick_inc = {1'b0, tick_r} + 17'd1;

  // one beat is executed whenever the queue holds one and the output stage can take its result
  assign take = avail & (~ovalid_r | out_ready);

  // bus sequencer, one base tick per beat
  always_comb begin
    ph_nxt     = ph_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    tick_nxt   = tick_r;
    poll_nxt   = poll_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    pend_nxt   = pend_r;
    ack_nxt    = ack_r;
    rx_nxt     = rx_r;
    status_nxt = status_r;
    ent        = 1'b0;
    ent_ph     = ph_r;
    done       = 1'b0;

    if (ph_r == PH_IDLE) begin
      // new command only looked at while idle
      if (item.kind != '0) begin
        status_nxt = 1'b0;
        bit_nxt    = 4'd0;
        poll_nxt   = 8'd0;
        pend_nxt   = item.stop_after;
        ack_nxt    = item.send_ack;
        ent        = 1'b1;
        if (item.kind.is_start) begin
          ent_ph = PH_S_PREP;
        end else if (item.kind.is_write) begin
          shift_nxt = item.tx_byte;
          ent_ph    = PH_W_LOW;
        end else if (item.kind.is_read) begin
          shift_nxt = 8'd0;
          ent_ph    = PH_R_LOW;
        end else begin
          ent_ph = PH_P_LOW;
        end
      end
    end else if (ph_r == PH_WA_POLL) begin
      // ack poll, one sample per tick
      if (!item.sda_in) begin
        ent    = 1'b1;
        ent_ph = PH_WA_HOLD;
      end else if (poll_r >= poll_limit) begin
        status_nxt = 1'b1;
        ent        = 1'b1;
        ent_ph     = PH_P_LOW;
      end else begin
        poll_nxt = poll_r + 8'd1;
      end
    end else if (tick_inc >= {1'b0, half}) begin
      // end of a timed phase
      case (ph_r)
        PH_S_PREP: begin ent = 1'b1; ent_ph = PH_S_HIGH; end
        PH_S_HIGH: begin ent = 1'b1; ent_ph = PH_S_FALL; end
        PH_S_FALL: begin
          scl_nxt = 1'b0;
          ph_nxt  = PH_IDLE;
          done    = 1'b1;
        end
        PH_W_LOW: begin ent = 1'b1; ent_ph = PH_W_HIGH; end
        PH_W_HIGH: begin
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_r + 4'd1;
          ent       = 1'b1;
          ent_ph    = (bit_nxt >= BitsPerByte) ? PH_WA_LOW : PH_W_LOW;
        end
        PH_WA_LOW: begin ent = 1'b1; ent_ph = PH_WA_POLL; end
        PH_R_LOW:  begin ent = 1'b1; ent_ph = PH_R_HIGH; end
        PH_R_HIGH: begin
          shift_nxt = {shift_r[6:0], item.sda_in};
          bit_nxt   = bit_r + 4'd1;
          ent       = 1'b1;
          if (bit_nxt >= BitsPerByte) begin
            rx_nxt = shift_nxt;
            ent_ph = PH_RA_LOW;
          end else begin
            ent_ph = PH_R_LOW;
          end
        end
        PH_RA_LOW: begin ent = 1'b1; ent_ph = PH_RA_HIGH; end
        PH_WA_HOLD, PH_RA_HIGH: begin
          // byte finished: clamp scl, then stop or complete
          scl_nxt = 1'b0;
          if (pend_r) begin
            ent    = 1'b1;
            ent_ph = PH_P_LOW;
          end else begin
            ph_nxt = PH_IDLE;
            done   = 1'b1;
          end
        end
        PH_P_LOW:  begin ent = 1'b1; ent_ph = PH_P_HIGH; end
        PH_P_HIGH: begin ent = 1'b1; ent_ph = PH_P_REL; end
        PH_P_REL: begin
          ph_nxt = PH_IDLE;
          done   = 1'b1;
        end
        default: ph_nxt = PH_IDLE;
      endcase
    end else begin
      tick_nxt = tick_inc[15:0];
    end

    // entering a phase sets the bus levels and restarts the divider
    if (ent) begin
      ph_nxt   = ent_ph;
      tick_nxt = 16'd0;
      case (ent_ph)
        PH_S_PREP:  begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        PH_S_HIGH:  begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        PH_S_FALL:  begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
        PH_W_LOW:   begin scl_nxt = 1'b0; sda_nxt = shift_nxt[7]; end
        PH_W_HIGH:  scl_nxt = 1'b1;
        PH_WA_LOW:  begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        PH_WA_POLL: begin scl_nxt = 1'b1; sda_nxt = 1'b1; poll_nxt = 8'd0; end
        PH_WA_HOLD: scl_nxt = 1'b1;
        PH_R_LOW:   begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        PH_R_HIGH:  scl_nxt = 1'b1;
        PH_RA_LOW:  begin scl_nxt = 1'b0; sda_nxt = ~ack_nxt; end
        PH_RA_HIGH: scl_nxt = 1'b1;
        PH_P_LOW:   begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
        PH_P_HIGH:  begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
        PH_P_REL:   begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        default:    scl_nxt = scl_r;
      endcase
    end
  end

  // output stage valid
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (take) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  // engine state, advanced on each executed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= PH_IDLE;
      bit_r    <= 4'd0;
      shift_r  <= 8'd0;
      tick_r   <= 16'd0;
      poll_r   <= 8'd0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      pend_r   <= 1'b0;
      ack_r    <= 1'b0;
      rx_r     <= 8'd0;
      status_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (take) begin
        ph_r     <= ph_nxt;
        bit_r    <= bit_nxt;
        shift_r  <= shift_nxt;
        tick_r   <= tick_nxt;
        poll_r   <= poll_nxt;
        scl_r    <= scl_nxt;
        sda_r    <= sda_nxt;
        pend_r   <= pend_nxt;
        ack_r    <= ack_nxt;
        rx_r     <= rx_nxt;
        status_r <= status_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take) begin
      odata_r <= {3'd0, status_nxt, rx_nxt, done, (ph_nxt != PH_IDLE), sda_nxt, scl_nxt};
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

endmodule

`default_nettype wire

// ===== sv/i2c_master_byte_engine.sv =====
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    tuser: cmd_valid, cmd; tdata: tx_byte, send_ack,
//                                      stop_after, sda_in
// out_     out  out_tvalid/out_tready  tdata: scl_out, sda_out, busy_res, done_res,
//                                      rx_byte, status
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one beat in, one beat out; a beat sustains one per cycle when out_tready is high
// each beat is held in the two-entry queue, then registered in the sequencer result register
// synchronous active-low reset; registers return to 100 and 10, bus lines released
// in_tready falls only when the queue is full behind a stalled output
// cfg_ready is always high; writes to indexes beyond the list are dropped
`default_nettype none

module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // tx_byte[7:0], send_ack, stop_after, sda_in, zeros
  input  wire logic [2:0]  in_tuser,   // cmd_valid, cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // scl_out, sda_out, busy_res, done_res, rx_byte[7:0],
                                       // status, zeros
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

`include "i2c_master_byte_engine_assert.svh"

  logic [15:0] half_r;
  logic [7:0]  limit_r;
  item_t       in_item;
  item_t       q_item;
  q_stat_t     q_stat;
  logic        push;
  logic        pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= HalfPeriodRst;
      limit_r <= PollLimitRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgHalfPeriod: half_r  <= cfg_data;
        CfgPollLimit:  limit_r <= cfg_data[7:0];
        default:       half_r  <= half_r;
      endcase
    end
  end

  // front: classify the incoming beat
  i2cm_front u_front (
    .cmd_valid  (in_tuser[0]),
    .cmd        (in_tuser[2:1]),
    .tx_byte    (in_tdata[7:0]),
    .send_ack   (in_tdata[8]),
    .stop_after (in_tdata[9]),
    .sda_in     (in_tdata[10]),
    .item       (in_item)
  );

  assign in_tready = ~q_stat.full;
  assign push      = in_tvalid & in_tready;

  // queue between front and back
  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (in_item),
    .pop       (pop),
    .pop_item  (q_item),
    .stat      (q_stat)
  );

  // back: bus sequencer and result register
  i2cm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .half_period (half_r),
    .poll_limit  (limit_r),
    .avail       (~q_stat.empty),
    .item        (q_item),
    .take        (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata)
  );

  // checks
  `I2CM_ASSERT_NOW(a_q_full_empty, q_stat.full, !q_stat.empty, "queue full and empty")
  `I2CM_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
  `I2CM_ASSERT_NOW(a_done_not_busy, out_tvalid && out_tdata[3], !out_tdata[2],
                   "done while still busy")
  `I2CM_ASSERT_NEXT(a_pop_gives_out, pop, out_tvalid, "executed beat gave no result")

endmodule

`default_nettype wire

// ===== sim/i2c_master_byte_engine_tb.sv =====
`timescale 1ns / 100ps

module i2c_master_byte_engine_tb
  import i2cm_pkg::*;
();

  // configuration indexes past the register list, writes there are dropped
  localparam logic [1:0] CfgSpareLo = 2'd2;
  localparam logic [1:0] CfgSpareHi = 2'd3;

  // slave that never pulls sda low during the ack poll
  localparam int NeverAck = 300;

  // one base tick as offered on the input channel
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] cmd;
    logic [7:0] tx;
    logic       sack;
    logic       stop;
    logic       sda;
  } tick_t;

  // bus state reported after one tick
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       status;
  } bus_res_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // tx_byte[7:0], send_ack, stop_after, sda_in, zeros
  logic [2:0]  in_tuser;   // cmd_valid, cmd[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // scl_out, sda_out, busy_res, done_res, rx_byte[7:0], status, zeros
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  bus_res_t bus_expect_q[$];
  int       fail_count = 0;
  int       ticks_sent = 0;
  int       hold_off_cycles = 0;
  bit       send_steady = 1'b0;
  bit       ready_steady = 1'b0;

  // predicted engine state and register copies
  phase_t      eng_phase;
  logic [3:0]  eng_bits;
  logic [7:0]  eng_shift;
  logic [15:0] eng_ticks;
  logic [7:0]  eng_polls;
  logic        eng_scl;
  logic        eng_sda;
  logic        eng_stop_pend;
  logic        eng_ack_sel;
  logic [7:0]  eng_rx;
  logic        eng_nack;
  logic [15:0] cfg_half;
  logic [7:0]  cfg_poll;

  i2c_master_byte_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // engine prediction

  function automatic void eng_reset();
    cfg_half      = HalfPeriodRst;
    cfg_poll      = PollLimitRst;
    eng_phase     = PH_IDLE;
    eng_bits      = '0;
    eng_shift     = '0;
    eng_ticks     = '0;
    eng_polls     = '0;
    eng_scl       = 1'b1;
    eng_sda       = 1'b1;
    eng_stop_pend = 1'b0;
    eng_ack_sel   = 1'b0;
    eng_rx        = '0;
    eng_nack      = 1'b0;
  endfunction

  // a new phase starts its own tick count and sets the bus levels
  function automatic void eng_enter(phase_t ph);
    eng_phase = ph;
    eng_ticks = '0;
    case (ph)
      PH_S_PREP: begin
        eng_scl = 1'b0; eng_sda = 1'b1;
      end
      PH_S_HIGH: begin
        eng_scl = 1'b1; eng_sda = 1'b1;
      end
      PH_S_FALL: begin
        eng_scl = 1'b1; eng_sda = 1'b0;
      end
      PH_W_LOW: begin
        eng_scl = 1'b0; eng_sda = eng_shift[7];
      end
      PH_W_HIGH:  eng_scl = 1'b1;
      PH_WA_LOW: begin
        eng_scl = 1'b0; eng_sda = 1'b1;
      end
      PH_WA_POLL: begin
        eng_scl = 1'b1; eng_sda = 1'b1; eng_polls = '0;
      end
      PH_WA_HOLD: eng_scl = 1'b1;
      PH_R_LOW: begin
        eng_scl = 1'b0; eng_sda = 1'b1;
      end
      PH_R_HIGH:  eng_scl = 1'b1;
      PH_RA_LOW: begin
        eng_scl = 1'b0; eng_sda = ~eng_ack_sel;
      end
      PH_RA_HIGH: eng_scl = 1'b1;
      PH_P_LOW: begin
        eng_scl = 1'b0; eng_sda = 1'b0;
      end
      PH_P_HIGH: begin
        eng_scl = 1'b1; eng_sda = 1'b0;
      end
      PH_P_REL: begin
        eng_scl = 1'b1; eng_sda = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // byte over: clamp scl low, then either stop or complete
  function automatic logic eng_byte_over();
    eng_scl = 1'b0;
    if (eng_stop_pend) begin
      eng_enter(PH_P_LOW);
      return 1'b0;
    end
    eng_phase = PH_IDLE;
    return 1'b1;
  endfunction

  // last tick of a timed phase, returns 1 when the command completes
  function automatic logic eng_phase_over(logic sda_in);
    logic fin;
    fin = 1'b0;
    case (eng_phase)
      PH_S_PREP: eng_enter(PH_S_HIGH);
      PH_S_HIGH: eng_enter(PH_S_FALL);
      PH_S_FALL: begin
        eng_scl = 1'b0; eng_phase = PH_IDLE; fin = 1'b1;
      end
      PH_W_LOW:  eng_enter(PH_W_HIGH);
      PH_W_HIGH: begin
        eng_shift = {eng_shift[6:0], 1'b0};
        eng_bits  = eng_bits + 4'd1;
        eng_enter(eng_bits >= BitsPerByte ? PH_WA_LOW : PH_W_LOW);
      end
      PH_WA_LOW:  eng_enter(PH_WA_POLL);
      PH_WA_HOLD: fin = eng_byte_over();
      PH_R_LOW:   eng_enter(PH_R_HIGH);
      PH_R_HIGH: begin
        eng_shift = {eng_shift[6:0], sda_in};
        eng_bits  = eng_bits + 4'd1;
        if (eng_bits >= BitsPerByte) begin
          eng_rx = eng_shift;
          eng_enter(PH_RA_LOW);
        end else begin
          eng_enter(PH_R_LOW);
        end
      end
      PH_RA_LOW:  eng_enter(PH_RA_HIGH);
      PH_RA_HIGH: fin = eng_byte_over();
      PH_P_LOW:   eng_enter(PH_P_HIGH);
      PH_P_HIGH:  eng_enter(PH_P_REL);
      PH_P_REL: begin
        eng_phase = PH_IDLE; fin = 1'b1;
      end
      default:    eng_phase = PH_IDLE;
    endcase
    return fin;
  endfunction

  // advance the engine by one base tick and report the bus state
  function automatic bus_res_t bus_tick(tick_t t);
    logic [16:0] half;
    logic [16:0] nxt;
    logic        fin;
    bus_res_t    r;
    half = (cfg_half == '0) ? 17'd1 : {1'b0, cfg_half};
    fin  = 1'b0;
    if (eng_phase == PH_IDLE) begin
      if (t.cmd_valid) begin
        eng_nack      = 1'b0;
        eng_bits      = '0;
        eng_polls     = '0;
        eng_stop_pend = 1'b0;
        eng_ack_sel   = t.sack;
        case (t.cmd)
          CmdStart: eng_enter(PH_S_PREP);
          CmdWrite: begin
            eng_shift     = t.tx;
            eng_stop_pend = t.stop;
            eng_enter(PH_W_LOW);
          end
          CmdRead: begin
            eng_shift     = '0;
            eng_stop_pend = t.stop;
            eng_enter(PH_R_LOW);
          end
          default:  eng_enter(PH_P_LOW);
        endcase
      end
    end else if (eng_phase == PH_WA_POLL) begin
      // one ack sample per tick, give up after the poll limit
      if (!t.sda) begin
        eng_enter(PH_WA_HOLD);
      end else if (eng_polls >= cfg_poll) begin
        eng_nack = 1'b1;
        eng_enter(PH_P_LOW);
      end else begin
        eng_polls = eng_polls + 8'd1;
      end
    end else begin
      nxt = {1'b0, eng_ticks} + 17'd1;
      if (nxt >= half) fin = eng_phase_over(t.sda);
      else eng_ticks = nxt[15:0];
    end
    r.scl    = eng_scl;
    r.sda    = eng_sda;
    r.busy   = (eng_phase != PH_IDLE);
    r.done   = fin;
    r.rx     = eng_rx;
    r.status = eng_nack;
    return r;
  endfunction

  // stimulus helpers

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  function automatic int ack_wait_pick();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 17) return $urandom_range(1, 4);
    return NeverAck;
  endfunction

  // one input beat, with the expected bus state queued on acceptance
  task automatic send_tick(tick_t t);
    if (!send_steady && $urandom_range(0, 99) < 12) begin
      in_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {t.cmd, t.cmd_valid};
    in_tdata  <= {5'd0, t.sda, t.stop, t.sack, t.tx};
    do @(posedge clk); while (!in_tready);
    bus_expect_q.push_back(bus_tick(t));
    ticks_sent++;
  endtask

  // ticks with no command, or with commands offered while busy when noisy
  task automatic send_filler(int n, bit noisy);
    tick_t t;
    repeat (n) begin
      t = 14'($urandom);
      t.cmd_valid = noisy ? 1'($urandom_range(0, 1)) : 1'b0;
      send_tick(t);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (bus_expect_q.size() != 0) @(posedge clk);
  endtask

  // both registers, then a dropped write past the list
  task automatic configure(logic [15:0] half, logic [15:0] poll);
    cfg_valid <= 1'b1;
    cfg_index <= CfgHalfPeriod;
    cfg_data  <= half;
    do @(posedge clk); while (!cfg_ready);
    cfg_half = half;
    cfg_index <= CfgPollLimit;
    cfg_data  <= poll;
    do @(posedge clk); while (!cfg_ready);
    cfg_poll = poll[7:0];
    cfg_index <= $urandom_range(0, 1) ? CfgSpareHi : CfgSpareLo;
    cfg_data  <= 16'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // tick the engine until idle, acting as the slave on sda
  task automatic run_to_idle(logic [7:0] rx_data, int ack_wait, bit noisy);
    tick_t t;
    int    wait_left;
    wait_left = ack_wait;
    while (eng_phase != PH_IDLE) begin
      t = 14'($urandom);
      t.cmd_valid = noisy ? 1'($urandom_range(0, 1)) : 1'b0;
      if (eng_phase == PH_WA_POLL) begin
        t.sda = (wait_left > 0);
        if (wait_left > 0) wait_left--;
      end else if (eng_phase == PH_R_LOW || eng_phase == PH_R_HIGH) begin
        t.sda = rx_data[3'd7 - eng_bits[2:0]];
      end
      send_tick(t);
    end
  endtask

  task automatic issue_command(logic [1:0] c, logic [7:0] tx, logic sack, logic stop);
    tick_t t;
    t = 14'($urandom);
    t.cmd_valid = 1'b1;
    t.cmd       = c;
    t.tx        = tx;
    t.sack      = sack;
    t.stop      = stop;
    send_tick(t);
  endtask

  task automatic run_command(logic [1:0] c, logic [7:0] tx, logic sack, logic stop,
                             logic [7:0] rx_data, int ack_wait, bit noisy);
    issue_command(c, tx, sack, stop);
    run_to_idle(rx_data, ack_wait, noisy);
  endtask

  task automatic random_command(logic [1:0] c, logic stop);
    run_command(c, 8'($urandom), 1'($urandom), stop, 8'($urandom), ack_wait_pick(),
                1'($urandom_range(0, 1)));
  endtask

  // tests

  // register reset values, idle bus before the first command
  task automatic test_reset_defaults();
    send_filler(3, 1'b0);
    // first phase runs at the reset half period, the rest at one tick
    issue_command(CmdStart, 8'h00, 1'b0, 1'b0);
    send_filler(100, 1'b0);
    drain();
    configure(16'd1, 16'd10);
    run_to_idle(8'h00, 0, 1'b0);
    send_filler(2, 1'b0);
  endtask

  // every command, ack boundary, nack with its own stop, commands while busy
  task automatic test_commands();
    drain();
    configure(16'd1, 16'd2);
    run_command(CmdStart, 8'h00, 1'b0, 1'b1, 8'h00, 0, 1'b0);
    run_command(CmdWrite, 8'hFF, 1'b0, 1'b0, 8'h00, 0, 1'b0);
    run_command(CmdWrite, 8'h00, 1'b1, 1'b0, 8'h00, 2, 1'b1);
    run_command(CmdRead,  8'h00, 1'b1, 1'b0, 8'hFF, 0, 1'b1);
    run_command(CmdRead,  8'hFF, 1'b0, 1'b1, 8'h00, 0, 1'b0);
    run_command(CmdStart, 8'h00, 1'b0, 1'b0, 8'h00, 0, 1'b0);
    run_command(CmdWrite, 8'h5A, 1'b0, 1'b0, 8'h00, 3, 1'b0);
    run_command(CmdRead,  8'hA5, 1'b1, 1'b0, 8'h3C, 0, 1'b0);
    run_command(CmdStop,  8'h00, 1'b0, 1'b1, 8'h00, 0, 1'b1);
    send_filler(2, 1'b0);
  endtask

  // zero half period, zero poll limit, masked poll limit data
  task automatic test_zero_settings();
    drain();
    configure(16'd0, 16'd0);
    run_command(CmdStart, 8'h00, 1'b0, 1'b0, 8'h00, 0, 1'b0);
    run_command(CmdWrite, 8'hC3, 1'b0, 1'b0, 8'h00, 1, 1'b0);
    run_command(CmdWrite, 8'h3C, 1'b0, 1'b1, 8'h00, 0, 1'b0);
    run_command(CmdRead,  8'h00, 1'b1, 1'b0, 8'h96, 0, 1'b0);
    drain();
    configure(16'd2, 16'hC703);
    run_command(CmdWrite, 8'h81, 1'b0, 1'b0, 8'h00, 3, 1'b0);
    run_command(CmdWrite, 8'h7E, 1'b0, 1'b0, 8'h00, 4, 1'b0);
  endtask

  // largest half period and poll limit
  task automatic test_long_settings();
    drain();
    configure(16'hFFFF, 16'h00FF);
    issue_command(CmdStart, 8'h00, 1'b0, 1'b0);
    send_filler(20, 1'b1);
    drain();
    // shorten the half period mid phase, the counter is already past it
    configure(16'd1, 16'h00FF);
    run_to_idle(8'h00, 0, 1'b0);
    run_command(CmdWrite, 8'h81, 1'b0, 1'b0, 8'h00, NeverAck, 1'b0);
    run_command(CmdWrite, 8'h7E, 1'b0, 1'b1, 8'h00, 3, 1'b1);
  endtask

  // output held off long enough to fill the block, then a full pause
  task automatic test_backpressure();
    drain();
    configure(16'd1, 16'd4);
    send_steady     = 1'b1;
    hold_off_cycles = 300;
    run_command(CmdStart, 8'h00, 1'b0, 1'b0, 8'h00, 0, 1'b0);
    run_command(CmdWrite, 8'hA6, 1'b0, 1'b0, 8'h00, 1, 1'b0);
    run_command(CmdRead,  8'h00, 1'b0, 1'b1, 8'h59, 0, 1'b1);
    drain();
    send_steady = 1'b0;
    run_command(CmdStart, 8'h00, 1'b0, 1'b0, 8'h00, 0, 1'b0);
    run_command(CmdStop,  8'h00, 1'b0, 1'b0, 8'h00, 0, 1'b0);
  endtask

  // mostly whole transfers with random content, some lone commands
  task automatic test_random(int n_ticks);
    int stop_at;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      drain();
      configure(16'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) :
                                                  $urandom_range(0, 3)),
                16'(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 6)));
      send_steady  = ($urandom_range(0, 3) == 0);
      ready_steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        if (ticks_sent < stop_at) begin
          send_filler($urandom_range(0, 3), 1'b0);
          if ($urandom_range(0, 9) < 7) begin
            random_command(CmdStart, 1'($urandom));
            random_command(CmdWrite, 1'b0);
            repeat ($urandom_range(1, 3)) begin
              random_command($urandom_range(0, 1) ? CmdWrite : CmdRead,
                             1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 3) != 0) random_command(CmdStop, 1'($urandom));
          end else begin
            random_command(2'($urandom), 1'($urandom));
          end
        end
      end
    end
    send_steady  = 1'b0;
    ready_steady = 1'b0;
  endtask

  // output side ready, with random gaps and requested hold-offs
  initial begin : tready_gen
    int n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!ready_steady && $urandom_range(0, 99) < 12) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest expected bus state
  always @(posedge clk) begin : bus_check
    bus_res_t got;
    bus_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.scl    = out_tdata[0];
      got.sda    = out_tdata[1];
      got.busy   = out_tdata[2];
      got.done   = out_tdata[3];
      got.rx     = out_tdata[11:4];
      got.status = out_tdata[12];
      if (bus_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("%0t: result beat with nothing expected", $realtime);
      end else begin
        want = bus_expect_q.pop_front();
        if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
            got.done !== want.done || got.rx !== want.rx || got.status !== want.status) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: mismatch exp scl %b sda %b busy %b done %b rx %h status %b",
                     $realtime, want.scl, want.sda, want.busy, want.done, want.rx,
                     want.status);
            $display("%0t:          got scl %b sda %b busy %b done %b rx %h status %b",
                     $realtime, got.scl, got.sda, got.busy, got.done, got.rx, got.status);
          end
        end
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    eng_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_commands();
    test_zero_settings();
    test_long_settings();
    test_backpressure();
    test_random(200);
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && bus_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== i2c_master_byte_engine.f =====
+incdir+sv
sv/i2cm_pkg.sv
sv/i2cm_front.sv
sv/i2cm_queue.sv
sv/i2cm_back.sv
sv/i2c_master_byte_engine.sv
sim/i2c_master_byte_engine_tb.sv
